// ===== src/mesh_vertex_normal_accumulator_core_macros.svh =====
// Assertion macros for the vertex normal accumulator core.
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_CORE_MACROS_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define MVNA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MVNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mvna_pkg.sv =====
// Shared types and constants of the vertex normal accumulator core.
package mvna_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_WRITE_VERTEX = 2'd0,
    OP_ADD_TRIANGLE = 2'd1,
    OP_READ_NORMAL  = 2'd2,
    OP_CLEAR_SUMS   = 2'd3
  } op_e;

  localparam int IDX_W   = 10;  // vertex index field width
  localparam int NORM_W  = 16;  // Q1.14 normal component width
  localparam int Q_FRAC  = 14;  // fraction bits of a normal component
  localparam int QUO_W   = Q_FRAC + 1;  // quotient bits, magnitude up to 1.0
  localparam int DIGIT_W = 16;  // digit width of the squaring multiplier

endpackage

// ===== src/mesh_vertex_normal_accumulator_core.sv =====
// Vertex normal accumulator core: position store, sum store and normalizer.
// Vertex write: the core stays ready. Triangle: three corner reads, edges, cross product,
// squaring over ND digits of 16 bits in a component magnitude (PW = 16*ND, 48 at
// defaults), square root, division, finish and three sum updates. Read: sum read, squaring,
// square root, division and finish; the square root unit retiring one result bit per cycle
// is the longest step. Clear, and reset: a sweep zeroes all sums, taking no request meanwhile.
module mesh_vertex_normal_accumulator_core
  import mvna_pkg::*;
#(
  parameter int VERTEX_COUNT = 1024,
  parameter int COORD_BITS   = 16,
  parameter int SUM_BITS     = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   operation_i,
  input  logic [IDX_W-1:0]             vtx_index_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic [IDX_W-1:0]             corner_first_i,
  input  logic [IDX_W-1:0]             corner_second_i,
  input  logic [IDX_W-1:0]             corner_third_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [IDX_W-1:0]             read_index_o,
  output logic signed [NORM_W-1:0]     normal_x_o,
  output logic signed [NORM_W-1:0]     normal_y_o,
  output logic signed [NORM_W-1:0]     normal_z_o,
  output logic                         zero_normal_o
);

`include "mesh_vertex_normal_accumulator_core_macros.svh"

  localparam int AW  = $clog2(VERTEX_COUNT);
  localparam int EW  = COORD_BITS + 1;
  localparam int PRW = 2 * EW;
  localparam int CW  = 2 * EW + 1;
  localparam int VW  = (CW > SUM_BITS) ? CW : SUM_BITS;
  localparam int ND  = (VW + DIGIT_W - 1) / DIGIT_W;
  localparam int PW  = ND * DIGIT_W;
  localparam int SSW = 2 * PW + 2;
  localparam int RW  = PW + 1;
  localparam int DGW = (ND > 1) ? $clog2(ND) : 1;
  localparam int VMW = 3 * COORD_BITS;
  localparam int SMW = 3 * SUM_BITS;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_VRD   = 4'd2;
  localparam logic [3:0] ST_EDGE  = 4'd3;
  localparam logic [3:0] ST_CROSS = 4'd4;
  localparam logic [3:0] ST_SRD   = 4'd5;
  localparam logic [3:0] ST_SQ    = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;
  localparam logic [3:0] ST_ARD   = 4'd10;
  localparam logic [3:0] ST_AWR   = 4'd11;

  // Control state
  logic [3:0]     state_q, state_d;
  logic [3:0]     step_q, step_d;
  logic [DGW-1:0] dig_q, dig_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic           out_valid_q, out_valid_d;

  // Memories
  logic [VMW-1:0] vmem [VERTEX_COUNT];
  logic [SMW-1:0] smem [VERTEX_COUNT];
  logic [VMW-1:0] vrdata_q;
  logic [SMW-1:0] srdata_q;
  logic [AW-1:0]  vraddr, sraddr, swaddr;
  logic [SMW-1:0] swdata;
  logic           vwe, swe;

  // Datapath registers
  logic [AW-1:0]                  k_q [3];
  logic [IDX_W-1:0]               idx_q;
  logic                           is_read_q, idx_ok_q, zero_q;
  logic signed [COORD_BITS-1:0]   p_q [3][3];
  logic signed [EW-1:0]           e1_q [3];
  logic signed [EW-1:0]           e2_q [3];
  logic signed [PRW-1:0]          tmp_q;
  logic signed [VW-1:0]           comp_q [3];
  logic [SSW-1:0]                 acc_q, res_q, bit_q;
  logic [RW:0]                    rem_q [3];
  logic [QUO_W-1:0]               quo_q [3];
  logic [IDX_W-1:0]               read_index_q;
  logic signed [NORM_W-1:0]       normal_q [3];
  logic                           zero_normal_q;

  // Combinational datapath
  logic                     in_acc, idx_ok, tri_ok, out_load;
  logic signed [EW-1:0]     cross_a, cross_b;
  logic signed [PRW-1:0]    cross_prod;
  logic signed [CW-1:0]     cross_c;
  logic [VW-1:0]            mag [3];
  logic [PW-1:0]            mag_pad;
  logic [DIGIT_W-1:0]       dig_val;
  logic [PW+DIGIT_W-1:0]    prod_sq;
  logic [SSW-1:0]           acc_d, sq_t;
  logic                     sq_ge;
  logic [RW-1:0]            root;
  logic                     div_ge [3];
  logic [RW:0]              rem_sub [3];
  logic signed [NORM_W-1:0] nq [3];
  logic signed [SUM_BITS:0] sat_w [3];
  logic [SUM_BITS-1:0]      sat_r [3];

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign idx_ok     = 32'(vtx_index_i) < VERTEX_COUNT;
  assign tri_ok     = (32'(corner_first_i) < VERTEX_COUNT) &&
                      (32'(corner_second_i) < VERTEX_COUNT) &&
                      (32'(corner_third_i) < VERTEX_COUNT);
  assign out_load   = (state_q == ST_FIN) && is_read_q && (!out_valid_q || out_ready_i);

  // Select cross product operands for the current partial product
  always_comb begin
    unique case (step_q)
      4'd0:    begin cross_a = e1_q[1]; cross_b = e2_q[2]; end
      4'd1:    begin cross_a = e2_q[1]; cross_b = e1_q[2]; end
      4'd2:    begin cross_a = e2_q[0]; cross_b = e1_q[2]; end
      4'd3:    begin cross_a = e1_q[0]; cross_b = e2_q[2]; end
      4'd4:    begin cross_a = e1_q[0]; cross_b = e2_q[1]; end
      4'd5:    begin cross_a = e2_q[0]; cross_b = e1_q[1]; end
      default: begin cross_a = e1_q[0]; cross_b = e2_q[0]; end
    endcase
  end

  assign cross_prod = PRW'(cross_a) * PRW'(cross_b);
  assign cross_c    = CW'(tmp_q) - CW'(cross_prod);

  // Component magnitudes and the squaring digit step
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = comp_q[j][VW-1] ? VW'(-comp_q[j]) : VW'(comp_q[j]);
    end
  end

  assign mag_pad = PW'(mag[step_q[1:0]]);
  assign dig_val = DIGIT_W'(mag_pad >> (DIGIT_W * (ND - 1 - int'(dig_q))));
  assign prod_sq = (PW + DIGIT_W)'(mag_pad) * (PW + DIGIT_W)'(dig_val);
  assign acc_d   = (step_q == 4'd0) ? (acc_q << DIGIT_W) + SSW'(prod_sq)
                                    : acc_q + SSW'(prod_sq);

  // Square root step
  assign sq_t  = res_q + bit_q;
  assign sq_ge = acc_q >= sq_t;
  assign root  = res_q[RW-1:0];

  // Division steps, face normal and saturating sums
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      div_ge[j]  = rem_q[j] >= (RW + 1)'(root);
      rem_sub[j] = div_ge[j] ? rem_q[j] - (RW + 1)'(root) : rem_q[j];
      nq[j]      = comp_q[j][VW-1] ? -NORM_W'(quo_q[j]) : NORM_W'(quo_q[j]);
      sat_w[j]   = (SUM_BITS + 1)'(signed'(srdata_q[j*SUM_BITS +: SUM_BITS])) +
                   (SUM_BITS + 1)'(nq[j]);
      if (sat_w[j][SUM_BITS] != sat_w[j][SUM_BITS-1]) begin
        sat_r[j] = sat_w[j][SUM_BITS] ? {1'b1, {(SUM_BITS - 1){1'b0}}}
                                      : {1'b0, {(SUM_BITS - 1){1'b1}}};
      end else begin
        sat_r[j] = sat_w[j][SUM_BITS-1:0];
      end
    end
  end

  // Memory addresses and write enables
  always_comb begin
    vwe    = in_acc && (op_e'(operation_i) == OP_WRITE_VERTEX) && idx_ok;
    vraddr = (state_q == ST_IDLE) ? AW'(corner_first_i)
           : (step_q == 4'd0)     ? k_q[1] : k_q[2];
    sraddr = (state_q == ST_IDLE) ? AW'(vtx_index_i) : k_q[step_q[1:0]];
    swe    = (state_q == ST_CLEAR) || (state_q == ST_AWR);
    swaddr = (state_q == ST_CLEAR) ? clr_q : k_q[step_q[1:0]];
    swdata = (state_q == ST_CLEAR) ? '0 : {sat_r[2], sat_r[1], sat_r[0]};
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    dig_d       = dig_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
    unique case (state_q)
      ST_CLEAR: begin
        if (32'(clr_q) == VERTEX_COUNT - 1) begin
          state_d = ST_IDLE;
        end
        clr_d = clr_q + AW'(1);
      end
      ST_IDLE: begin
        if (in_acc) begin
          step_d = 4'd0;
          unique case (op_e'(operation_i))
            OP_WRITE_VERTEX: state_d = ST_IDLE;
            OP_ADD_TRIANGLE: state_d = tri_ok ? ST_VRD : ST_IDLE;
            OP_READ_NORMAL:  state_d = ST_SRD;
            OP_CLEAR_SUMS: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
            end
            default:         state_d = ST_IDLE;
          endcase
        end
      end
      ST_VRD: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd2) begin
          state_d = ST_EDGE;
          step_d  = 4'd0;
        end
      end
      ST_EDGE: begin
        state_d = ST_CROSS;
        step_d  = 4'd0;
      end
      ST_CROSS: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd5) begin
          state_d = ST_SQ;
          step_d  = 4'd0;
          dig_d   = '0;
        end
      end
      ST_SRD: begin
        state_d = ST_SQ;
        step_d  = 4'd0;
        dig_d   = '0;
      end
      ST_SQ: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd2) begin
          step_d = 4'd0;
          dig_d  = dig_q + DGW'(1);
          if (32'(dig_q) == ND - 1) begin
            state_d = (acc_d == '0) ? ST_FIN : ST_SQRT;
          end
        end
      end
      ST_SQRT: begin
        if (bit_q[0]) begin
          state_d = ST_DIV;
          step_d  = 4'd0;
        end
      end
      ST_DIV: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'(QUO_W - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        step_d = 4'd0;
        if (!is_read_q) begin
          state_d = ST_ARD;
        end else if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_ARD: state_d = ST_AWR;
      ST_AWR: begin
        step_d  = step_q + 4'd1;
        state_d = (step_q == 4'd2) ? ST_IDLE : ST_ARD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      step_q      <= '0;
      dig_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Position store
  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[AW'(vtx_index_i)] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    vrdata_q <= vmem[vraddr];
  end

  // Sum store
  always_ff @(posedge clk_i) begin
    if (swe) begin
      smem[swaddr] <= swdata;
    end
    srdata_q <= smem[sraddr];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      k_q[0]    <= AW'(corner_first_i);
      k_q[1]    <= AW'(corner_second_i);
      k_q[2]    <= AW'(corner_third_i);
      idx_q     <= vtx_index_i;
      is_read_q <= (op_e'(operation_i) == OP_READ_NORMAL);
      idx_ok_q  <= idx_ok;
    end
    unique case (state_q)
      ST_VRD: begin
        for (int j = 0; j < 3; j++) begin
          p_q[step_q[1:0]][j] <= vrdata_q[j*COORD_BITS +: COORD_BITS];
        end
      end
      ST_EDGE: begin
        for (int j = 0; j < 3; j++) begin
          e1_q[j] <= EW'(p_q[1][j]) - EW'(p_q[0][j]);
          e2_q[j] <= EW'(p_q[2][j]) - EW'(p_q[0][j]);
        end
        acc_q <= '0;
      end
      ST_CROSS: begin
        if (!step_q[0]) begin
          tmp_q <= cross_prod;
        end else begin
          comp_q[step_q[2:1]] <= VW'(cross_c);
        end
      end
      ST_SRD: begin
        for (int j = 0; j < 3; j++) begin
          comp_q[j] <= idx_ok_q ? VW'(signed'(srdata_q[j*SUM_BITS +: SUM_BITS])) : '0;
        end
        acc_q <= '0;
      end
      ST_SQ: begin
        acc_q <= acc_d;
        bit_q <= SSW'(1) << (SSW - 2);
        res_q <= '0;
        zero_q <= (acc_d == '0);
        for (int j = 0; j < 3; j++) begin
          quo_q[j] <= '0;
        end
      end
      ST_SQRT: begin
        if (sq_ge) begin
          acc_q <= acc_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        for (int j = 0; j < 3; j++) begin
          rem_q[j] <= (RW + 1)'(mag[j]);
        end
      end
      ST_DIV: begin
        for (int j = 0; j < 3; j++) begin
          rem_q[j] <= rem_sub[j] << 1;
          quo_q[j] <= {quo_q[j][QUO_W-2:0], div_ge[j]};
        end
      end
      default: begin
      end
    endcase
    // Hold the result until it is taken
    if (out_load) begin
      read_index_q  <= idx_q;
      normal_q[0]   <= nq[0];
      normal_q[1]   <= nq[1];
      normal_q[2]   <= nq[2];
      zero_normal_q <= zero_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_index_o  = read_index_q;
  assign normal_x_o    = normal_q[0];
  assign normal_y_o    = normal_q[1];
  assign normal_z_o    = normal_q[2];
  assign zero_normal_o = zero_normal_q;

  `MVNA_ASSERT_SAME(a_out_from_fin, $rose(out_valid_q), $past(state_q) == ST_FIN, "result loaded outside finish")
  `MVNA_ASSERT_SAME(a_rem_bound, state_q == ST_DIV, (rem_q[0] < ((RW + 1)'(root) << 1)) && (rem_q[1] < ((RW + 1)'(root) << 1)) && (rem_q[2] < ((RW + 1)'(root) << 1)), "divider remainder out of range")
  `MVNA_ASSERT_SAME(a_clear_zero, state_q == ST_CLEAR, swe && (swdata == '0), "clear sweep writes nonzero sum")
  `MVNA_ASSERT_NEXT(a_awr_next, state_q == ST_AWR, (state_q == ST_ARD) || (state_q == ST_IDLE), "sum update sequence broken")

endmodule

// ===== sim/tb_mesh_vertex_normal_accumulator_core.sv =====
// Self-checking testbench for the vertex normal accumulator core.
module tb_mesh_vertex_normal_accumulator_core
  import mvna_pkg::*;
;

  localparam int NVERT  = 1024;
  localparam int CW     = 16;
  // Narrow sums so that saturation is reached within the run
  localparam int SUM_W  = 20;
  localparam int NRAND  = 1800;
  localparam int QUIET_LO = 700;
  localparam int QUIET_HI = 1000;

  typedef struct {
    op_e                  op;
    logic [IDX_W-1:0]     idx;
    logic signed [CW-1:0] px, py, pz;
    logic [IDX_W-1:0]     ca, cb, cc;
    bit                   drain;
  } request_t;

  typedef struct {
    logic [IDX_W-1:0]         idx;
    logic signed [NORM_W-1:0] nx, ny, nz;
    logic                     zero;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] operation = '0;
  logic [IDX_W-1:0] vtx_index = '0;
  logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [IDX_W-1:0] corner_first = '0, corner_second = '0, corner_third = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] read_index;
  logic signed [NORM_W-1:0] normal_x, normal_y, normal_z;
  logic zero_normal;

  request_t pending_q[$];
  normal_t  normal_q[$];
  bit       placed[NVERT];
  int       placed_list[$];
  int       sent = 0, errors = 0, reads_checked = 0, sat_hits = 0, zero_reads = 0;
  bit       stim_done = 1'b0;

  logic signed [CW-1:0]    vpos[NVERT][3];
  logic signed [SUM_W-1:0] sums[NVERT][3];

  always #1 clk = ~clk;

  mesh_vertex_normal_accumulator_core #(
    .VERTEX_COUNT(NVERT),
    .COORD_BITS  (CW),
    .SUM_BITS    (SUM_W)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .vtx_index_i    (vtx_index),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .pos_z_i        (pos_z),
    .corner_first_i (corner_first),
    .corner_second_i(corner_second),
    .corner_third_i (corner_third),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .read_index_o   (read_index),
    .normal_x_o     (normal_x),
    .normal_y_o     (normal_y),
    .normal_z_o     (normal_z),
    .zero_normal_o  (zero_normal)
  );

  // Floor square root of a wide unsigned value, one result bit per step
  function automatic logic [127:0] floor_sqrt(logic [127:0] x);
    logic [127:0] res, bitv;
    res = '0;
    bitv = 128'd1 << 126;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Scale a vector to unit length in Q1.14; returns 1 for the zero vector
  function automatic bit unit_vector(input longint v[3], output longint q[3]);
    logic [127:0] mag[3], sq, root, quo;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? 128'(-v[i]) : 128'(v[i]);
      sq += mag[i] * mag[i];
    end
    if (sq == 0) begin
      q = '{0, 0, 0};
      return 1'b1;
    end
    root = floor_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      quo = (mag[i] << Q_FRAC) / root;
      if (quo > 32767) quo = 32767;
      q[i] = (v[i] < 0) ? -longint'(quo) : longint'(quo);
    end
    return 1'b0;
  endfunction

  // Apply one accepted request to the shadow state, queue any normal it yields
  task automatic apply_request(request_t r);
    longint e1[3], e2[3], c[3], q[3], t;
    longint lim;
    int k[3];
    normal_t n;
    lim = longint'(1) << (SUM_W - 1);
    case (r.op)
      OP_WRITE_VERTEX: begin
        vpos[r.idx][0] = r.px;
        vpos[r.idx][1] = r.py;
        vpos[r.idx][2] = r.pz;
      end
      OP_ADD_TRIANGLE: begin
        k = '{int'(r.ca), int'(r.cb), int'(r.cc)};
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(vpos[k[1]][i]) - longint'(vpos[k[0]][i]);
          e2[i] = longint'(vpos[k[2]][i]) - longint'(vpos[k[0]][i]);
        end
        c[0] = e1[1] * e2[2] - e2[1] * e1[2];
        c[1] = e2[0] * e1[2] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e2[0] * e1[1];
        void'(unit_vector(c, q));
        for (int j = 0; j < 3; j++) begin
          for (int i = 0; i < 3; i++) begin
            t = longint'(sums[k[j]][i]) + q[i];
            if (t > lim - 1) begin t = lim - 1; sat_hits++; end
            if (t < -lim) begin t = -lim; sat_hits++; end
            sums[k[j]][i] = t[SUM_W-1:0];
          end
        end
      end
      OP_READ_NORMAL: begin
        for (int i = 0; i < 3; i++) c[i] = sums[r.idx][i];
        n.zero = unit_vector(c, q);
        n.idx = r.idx;
        n.nx = q[0][NORM_W-1:0];
        n.ny = q[1][NORM_W-1:0];
        n.nz = q[2][NORM_W-1:0];
        if (n.zero) zero_reads++;
        normal_q.insert(normal_q.size(), n);
      end
      default: begin
        for (int v = 0; v < NVERT; v++) sums[v] = '{default: '0};
      end
    endcase
  endtask

  task automatic report(string what, longint got, longint want);
    $display("error at %0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Request builders used by the stimulus
  task automatic add_write(int idx, int x, int y, int z);
    request_t r;
    r = '{OP_WRITE_VERTEX, IDX_W'(idx), CW'(x), CW'(y), CW'(z),
          IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), 1'b0};
    pending_q.insert(pending_q.size(), r);
    if (!placed[idx]) begin
      placed[idx] = 1'b1;
      placed_list.insert(placed_list.size(), idx);
    end
  endtask

  task automatic add_triangle(int a, int b, int c);
    request_t r;
    r = '{OP_ADD_TRIANGLE, IDX_W'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
          IDX_W'(a), IDX_W'(b), IDX_W'(c), 1'b0};
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic add_read(int idx, bit drain);
    request_t r;
    r = '{OP_READ_NORMAL, IDX_W'(idx), CW'($urandom), CW'($urandom), CW'($urandom),
          IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), drain};
    pending_q.insert(pending_q.size(), r);
  endtask

  task automatic add_clear(bit drain);
    request_t r;
    r = '{OP_CLEAR_SUMS, IDX_W'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
          IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), drain};
    pending_q.insert(pending_q.size(), r);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 64) - 32;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  function automatic int pick_corner(int hot_n);
    if (placed_list.size() > hot_n && $urandom_range(0, 3) == 0)
      return placed_list[$urandom_range(0, placed_list.size() - 1)];
    return placed_list[$urandom_range(0, hot_n - 1)];
  endfunction

  // Fill the request queue: directed cases, then random traffic
  initial begin
    int a, b, c;
    for (int v = 0; v < NVERT; v++) begin
      vpos[v] = '{default: '0};
      sums[v] = '{default: '0};
    end
    // extreme coordinates, a full triangle, a degenerate one and a repeated corner
    add_write(0, -32768, -32768, -32768);
    add_write(1, 32767, -32768, 32767);
    add_write(2, -32768, 32767, 32767);
    add_write(3, 0, 0, 0);
    add_write(1023, 32767, 32767, -32768);
    add_read(700, 1'b0);
    add_triangle(0, 1, 2);
    add_triangle(0, 0, 1);
    add_triangle(3, 3, 3);
    add_triangle(1023, 2, 1);
    add_read(0, 1'b0);
    add_read(1, 1'b0);
    add_read(2, 1'b0);
    add_read(1023, 1'b0);
    add_read(3, 1'b0);
    add_clear(1'b1);
    add_read(0, 1'b0);
    add_triangle(2, 1, 0);
    add_read(2, 1'b1);
    // random traffic over a small hot set so sums saturate, plus the full range
    for (int v = 4; v < 12; v++) add_write(v, pick_coord(), pick_coord(), pick_coord());
    for (int n = 0; n < NRAND; n++) begin
      case ($urandom_range(0, 99)) inside
        [0:24]: begin
          a = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NVERT - 1)
                                          : $urandom_range(0, 11);
          add_write(a, pick_coord(), pick_coord(), pick_coord());
        end
        [25:64]: begin
          a = pick_corner(12);
          b = ($urandom_range(0, 5) == 0) ? a : pick_corner(12);
          c = ($urandom_range(0, 5) == 0) ? b : pick_corner(12);
          add_triangle(a, b, c);
        end
        [65:98]: begin
          a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NVERT - 1)
                                          : $urandom_range(0, 11);
          add_read(a, n == 400);
        end
        default: add_clear(1'b0);
      endcase
    end
  end

  // Drive requests, holding each until it is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (in_valid) begin
          apply_request('{op_e'(operation), vtx_index, pos_x, pos_y, pos_z,
                          corner_first, corner_second, corner_third, 1'b0});
          sent++;
        end
        if (pending_q.size() != 0 &&
            !(pending_q[0].drain && normal_q.size() != 0 && !(in_valid && in_ready)) &&
            ((sent >= QUIET_LO && sent < QUIET_HI) || $urandom_range(0, 99) >= 22)) begin
          if (pending_q[0].drain && normal_q.size() != 0) begin
            in_valid <= 1'b0;
          end else begin
            request_t r;
            r = pending_q.pop_front();
            in_valid      <= 1'b1;
            operation     <= r.op;
            vtx_index     <= r.idx;
            pos_x         <= r.px;
            pos_y         <= r.py;
            pos_z         <= r.pz;
            corner_first  <= r.ca;
            corner_second <= r.cb;
            corner_third  <= r.cc;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take results and compare them with the oldest expected normal
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (normal_q.size() == 0) begin
          report("unexpected result, index", read_index, -1);
        end else begin
          normal_t n;
          n = normal_q.pop_front();
          if (read_index != n.idx) report("read_index", read_index, n.idx);
          if (normal_x != n.nx) report("normal_x", normal_x, n.nx);
          if (normal_y != n.ny) report("normal_y", normal_y, n.ny);
          if (normal_z != n.nz) report("normal_z", normal_z, n.nz);
          if (zero_normal != n.zero) report("zero_normal", zero_normal, n.zero);
          reads_checked++;
        end
      end
      out_ready <= (sent >= QUIET_LO && sent < QUIET_HI) || ($urandom_range(0, 99) >= 22);
    end
  end

  // Reset, wait for all traffic to drain, then judge the run
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_q.size() == 0 && !in_valid && normal_q.size() == 0);
    repeat (200) @(posedge clk);
    $display("%0d requests taken, %0d normals checked (%0d zero), %0d saturating adds",
             sent, reads_checked, zero_reads, sat_hits);
    if (errors == 0 && normal_q.size() == 0) begin
      $display("mesh_vertex_normal_accumulator_core: match");
    end else begin
      $display("mesh_vertex_normal_accumulator_core: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #4000000;
    $display("timeout with %0d normals outstanding", normal_q.size());
    $display("mesh_vertex_normal_accumulator_core: mismatch");
    $finish;
  end

endmodule
